// ===== rtl/fpa_pkg.sv =====
`timescale 1ns / 1ps
package fpa_pkg;

  localparam int DATA_W        = 32;
  localparam int FRAC_BITS_DEF = 8;

  localparam logic [3:0] OP_ADD = 4'd0;
  localparam logic [3:0] OP_SUB = 4'd1;
  localparam logic [3:0] OP_MUL = 4'd2;
  localparam logic [3:0] OP_DIV = 4'd3;
  localparam logic [3:0] OP_INC = 4'd4;
  localparam logic [3:0] OP_DEC = 4'd5;
  localparam logic [3:0] OP_I2F = 4'd6;
  localparam logic [3:0] OP_F2I = 4'd7;
  localparam logic [3:0] OP_MAX = 4'd8;
  localparam logic [3:0] OP_MIN = 4'd9;

  // result and flags that ride alongside the divider
  typedef struct packed {
    logic              is_div;
    logic [DATA_W-1:0] value;
    logic              lt;
    logic              eq;
    logic              gt;
    logic              dz;
  } tag_t;

endpackage

// ===== rtl/fpa_div.sv =====
`timescale 1ns / 1ps
module fpa_div #(
  parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   en,
  input  logic                                   in_valid,
  input  logic [fpa_pkg::DATA_W+FRAC_BITS-1:0]   num,
  input  logic [fpa_pkg::DATA_W-1:0]             den,
  input  logic                                   neg,
  input  fpa_pkg::tag_t                          tag,
  output logic                                   out_valid,
  output logic [fpa_pkg::DATA_W-1:0]             quot,
  output logic                                   out_neg,
  output fpa_pkg::tag_t                          out_tag
);
  import fpa_pkg::*;

  localparam int NUMW = DATA_W + FRAC_BITS;

  logic              v_s   [0:NUMW];
  logic [NUMW-1:0]   num_s [0:NUMW];
  logic [DATA_W-1:0] den_s [0:NUMW];
  logic [DATA_W-1:0] rem_s [0:NUMW];
  logic [DATA_W-1:0] q_s   [0:NUMW];
  logic              neg_s [0:NUMW];
  tag_t              tag_s [0:NUMW];

  assign v_s[0]   = in_valid;
  assign num_s[0] = num;
  assign den_s[0] = den;
  assign rem_s[0] = '0;
  assign q_s[0]   = '0;
  assign neg_s[0] = neg;
  assign tag_s[0] = tag;

  // one quotient bit per stage, restoring
  for (genvar g = 0; g < NUMW; g++) begin : g_stage
    logic [DATA_W:0] trial;
    logic            ge;
    assign trial = {rem_s[g], num_s[g][NUMW-1]};
    assign ge    = trial >= {1'b0, den_s[g]};

    always_ff @(posedge clk) begin
      if (rst) begin
        v_s[g+1] <= 1'b0;
      end else if (en) begin
        v_s[g+1] <= v_s[g];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_s[g+1] <= ge ? DATA_W'(trial - {1'b0, den_s[g]}) : trial[DATA_W-1:0];
        num_s[g+1] <= {num_s[g][NUMW-2:0], 1'b0};
        q_s[g+1]   <= {q_s[g][DATA_W-2:0], ge};
        den_s[g+1] <= den_s[g];
        neg_s[g+1] <= neg_s[g];
        tag_s[g+1] <= tag_s[g];
      end
    end
  end

  assign out_valid = v_s[NUMW];
  assign quot      = q_s[NUMW];
  assign out_neg   = neg_s[NUMW];
  assign out_tag   = tag_s[NUMW];

endmodule

// ===== rtl/fixed_point_alu_unit.sv =====
`timescale 1ns / 1ps
// Signed fixed-point ALU, 32-bit raw values with FRAC_BITS fraction bits. One word is
// accepted per clock unless the output is stalled. Every word passes through the divider,
// which resolves one quotient bit per stage over 32+FRAC_BITS stages, and through the
// input, operand and output registers. All opcodes run the same depth, so results leave
// in order. A stalled output holds the whole pipeline.
module fixed_point_alu_unit #(
  parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,  // operand_a[31:0], operand_b[63:32]
  input  logic [3:0]  s_tuser,  // req_type[3:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,  // result_value[31:0]
  output logic [3:0]  m_tuser   // a_less, a_equal, a_greater, divide_by_zero
);
  import fpa_pkg::*;

  localparam int NUMW = DATA_W + FRAC_BITS;

  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // stage A: input register
  logic                     va;
  logic [3:0]               op_a;
  logic signed [DATA_W-1:0] a_a, b_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (en) begin
      va <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op_a <= s_tuser;
      a_a  <= s_tdata[31:0];
      b_a  <= s_tdata[63:32];
    end
  end

  // stage B: multiply, simple ops, divider operands
  logic [DATA_W-1:0] simple;
  logic              lt, eq, gt;
  logic [DATA_W-1:0] abs_a, abs_b;

  assign lt    = a_a < b_a;
  assign eq    = a_a == b_a;
  assign gt    = a_a > b_a;
  assign abs_a = a_a[DATA_W-1] ? DATA_W'(-a_a) : a_a;
  assign abs_b = b_a[DATA_W-1] ? DATA_W'(-b_a) : b_a;

  always_comb begin
    case (op_a)
      OP_ADD:  simple = DATA_W'(a_a + b_a);
      OP_SUB:  simple = DATA_W'(a_a - b_a);
      OP_INC:  simple = DATA_W'(a_a + 1);
      OP_DEC:  simple = DATA_W'(a_a - 1);
      OP_I2F:  simple = DATA_W'(a_a <<< FRAC_BITS);
      OP_F2I:  simple = DATA_W'(a_a >>> FRAC_BITS);
      OP_MAX:  simple = gt ? a_a : b_a;
      OP_MIN:  simple = lt ? a_a : b_a;
      default: simple = '0;
    endcase
  end

  logic                       vb;
  logic signed [2*DATA_W-1:0] prod_b;
  logic                       is_mul_b;
  tag_t                       tag_b;
  logic [NUMW-1:0]            num_b;
  logic [DATA_W-1:0]          den_b;
  logic                       neg_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else if (en) begin
      vb <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_b       <= a_a * b_a;
      is_mul_b     <= op_a == OP_MUL;
      tag_b.is_div <= op_a == OP_DIV;
      tag_b.value  <= simple;
      tag_b.lt     <= lt;
      tag_b.eq     <= eq;
      tag_b.gt     <= gt;
      tag_b.dz     <= (op_a == OP_DIV) && (b_a == '0);
      num_b        <= {abs_a, {FRAC_BITS{1'b0}}};
      den_b        <= abs_b;
      neg_b        <= a_a[DATA_W-1] ^ b_a[DATA_W-1];
    end
  end

  tag_t tag_in;
  always_comb begin
    tag_in = tag_b;
    if (is_mul_b) begin
      tag_in.value = prod_b[FRAC_BITS+DATA_W-1:FRAC_BITS];
    end
  end

  logic              dv;
  logic [DATA_W-1:0] dq;
  logic              dneg;
  tag_t              dtag;

  fpa_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (vb),
    .num       (num_b),
    .den       (den_b),
    .neg       (neg_b),
    .tag       (tag_in),
    .out_valid (dv),
    .quot      (dq),
    .out_neg   (dneg),
    .out_tag   (dtag)
  );

  // output register
  logic [DATA_W-1:0] res_next;
  always_comb begin
    if (!dtag.is_div) begin
      res_next = dtag.value;
    end else if (dtag.dz) begin
      res_next = '0;
    end else begin
      res_next = dneg ? DATA_W'(-dq) : dq;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= dv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= res_next;
      m_tuser <= {dtag.dz, dtag.gt, dtag.eq, dtag.lt};
    end
  end

endmodule

// ===== rtl/fpa_checker.sv =====
`timescale 1ns / 1ps
module fpa_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic [3:0]  m_tuser
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("output word changed while stalled");

  a_flags: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> $onehot(m_tuser[2:0]))
    else $error("compare flags not one-hot");

  a_dz: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[3] |-> m_tdata == 32'd0)
    else $error("divide by zero with nonzero result");

  a_stall: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !s_tready)
    else $error("input taken while pipeline stalled");

endmodule

bind fixed_point_alu_unit fpa_checker u_fpa_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

// ===== sim/fixed_point_alu_checker.sv =====
`timescale 1ns / 1ps
module fixed_point_alu_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [63:0] s_tdata,
  input  logic [3:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [31:0] m_tdata,
  input  logic [3:0]  m_tuser,
  output int          fail_count,
  output int          pending
);
  import fpa_pkg::*;

  typedef struct packed {
    logic [31:0] value;
    logic        lt;
    logic        eq;
    logic        gt;
    logic        dz;
  } alu_result_t;

  alu_result_t result_q[$];
  int shown;

  function automatic alu_result_t alu_predict(logic [3:0] op, logic signed [31:0] a,
                                              logic signed [31:0] b);
    alu_result_t r;
    logic signed [63:0] wa;
    logic signed [63:0] wb;
    logic signed [63:0] prod;
    logic signed [63:0] num;
    wa = a;
    wb = b;
    r = '0;
    r.lt = a < b;
    r.eq = a == b;
    r.gt = a > b;
    case (op)
      OP_ADD: r.value = a + b;
      OP_SUB: r.value = a - b;
      OP_MUL: begin
        prod = wa * wb;
        r.value = prod >>> FRAC_BITS_DEF;
      end
      OP_DIV: begin
        if (b == 0) begin
          r.dz = 1'b1;
        end else begin
          num = wa <<< FRAC_BITS_DEF;
          r.value = num / wb;
        end
      end
      OP_INC: r.value = a + 1;
      OP_DEC: r.value = a - 1;
      OP_I2F: r.value = a <<< FRAC_BITS_DEF;
      OP_F2I: r.value = a >>> FRAC_BITS_DEF;
      OP_MAX: r.value = (a > b) ? a : b;
      OP_MIN: r.value = (a < b) ? a : b;
      default: r.value = '0;
    endcase
    return r;
  endfunction

  assign pending = result_q.size();

  always @(posedge clk) begin
    alu_result_t exp_r;
    alu_result_t got;
    if (rst) begin
      fail_count <= 0;
      shown = 0;
    end else begin
      if (s_tvalid && s_tready)
        result_q.push_back(alu_predict(s_tuser, s_tdata[31:0], s_tdata[63:32]));
      if (m_tvalid && m_tready) begin
        got = {m_tdata, m_tuser[0], m_tuser[1], m_tuser[2], m_tuser[3]};
        if (result_q.size() == 0) begin
          fail_count <= fail_count + 1;
          if (shown < 10) $display("unexpected word: %h", got);
          shown++;
        end else begin
          exp_r = result_q.pop_front();
          if (got !== exp_r) begin
            fail_count <= fail_count + 1;
            if (shown < 10)
              $display("mismatch: exp value %h lt %b eq %b gt %b dz %b, got value %h lt %b eq %b gt %b dz %b",
                       exp_r.value, exp_r.lt, exp_r.eq, exp_r.gt, exp_r.dz,
                       got.value, got.lt, got.eq, got.gt, got.dz);
            shown++;
          end
        end
      end
    end
  end
endmodule

// ===== sim/fixed_point_alu_unit_tb.sv =====
`timescale 1ns / 1ps
module fixed_point_alu_unit_tb;
  import fpa_pkg::*;

  localparam int LATENCY = FRAC_BITS_DEF + 34;
  localparam int N_RANDOM = 930;
  localparam int LIMIT = 200000;

  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;
  logic [3:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [31:0] m_tdata;
  logic [3:0]  m_tuser;
  int          fail_count;
  int          pending;
  int          cycles = 0;
  bit          hold_off = 0;

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  fixed_point_alu_unit DUT (.*);

  fixed_point_alu_checker checker_i (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // receiver: random stall per word, plus a long hold-off per word while hold_off is set
  initial begin
    int w;
    @(posedge clk iff !rst);
    forever begin
      w = $urandom_range(3) == 0 ? 0 : $urandom_range(12);
      if (hold_off) w = 300;
      if (w > 0) begin
        m_tready <= 0;
        repeat (w) @(posedge clk);
      end
      m_tready <= 1;
      @(posedge clk iff m_tvalid);
    end
  end

  task automatic send_word(logic [3:0] op, logic [31:0] a, logic [31:0] b, int gap);
    if (gap > 0) begin
      s_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tuser <= op;
    s_tdata <= {b, a};
    @(posedge clk iff s_tready);
  endtask

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(5))
      0: return 32'h8000_0000 + $urandom_range(3);
      1: return 32'h7fff_fffc + $urandom_range(3);
      2: return $urandom_range(4) - 2;
      3: return $urandom_range(2048) - 1024;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic [31:0] edges[5] = '{32'h8000_0000, 32'h7fff_ffff, 0, 32'hffff_ffff, 32'h100};
    int gap;
    repeat (10) @(posedge clk);
    rst <= 0;
    for (int op = 0; op < 16; op++)
      send_word(op[3:0], edges[op % 5], edges[(op + 2) % 5], 0);
    send_word(OP_DIV, 32'h0000_0300, 0, 0);
    send_word(OP_DIV, 32'h8000_0000, 32'hffff_ffff, 0);
    send_word(OP_DIV, 32'hffff_fd00, 32'h0000_0200, 0);
    send_word(OP_MUL, 32'hffff_ffff, 32'h0000_0001, 0);
    send_word(OP_MAX, 32'h1234, 32'h1234, 0);
    send_word(OP_MIN, 32'h8000_0000, 32'h7fff_ffff, 0);
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == 300) hold_off = 1;
      if (i == 400) hold_off = 0;
      gap = (i % 200 < 60 || hold_off) ? 0 : $urandom_range(12);
      send_word(4'($urandom_range(7) == 0 ? $urandom_range(15) : $urandom_range(9)),
                pick_operand(), $urandom_range(9) == 0 ? 0 : pick_operand(), gap);
    end
    s_tvalid <= 0;
    wait (pending == 0);
    repeat (LATENCY + 10) @(posedge clk);
    if (fail_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
